### sv/brf_pkg.sv
// Shared types, codes and slot mapping for the banked register file.
package brf_pkg;

  // Operation codes carried in the opcode field.
  localparam logic [2:0] OP_RD_BANKED = 3'd0;
  localparam logic [2:0] OP_WR_BANKED = 3'd1;
  localparam logic [2:0] OP_RD_USER   = 3'd2;
  localparam logic [2:0] OP_WR_USER   = 3'd3;
  localparam logic [2:0] OP_RD_CPSR   = 3'd4;
  localparam logic [2:0] OP_WR_CPSR   = 3'd5;
  localparam logic [2:0] OP_RD_SPSR   = 3'd6;
  localparam logic [2:0] OP_WR_SPSR   = 3'd7;

  // Processor mode encodings in CPSR bits 4..0.
  localparam logic [4:0] MODE_USR = 5'h10;
  localparam logic [4:0] MODE_FIQ = 5'h11;
  localparam logic [4:0] MODE_IRQ = 5'h12;
  localparam logic [4:0] MODE_SVC = 5'h13;
  localparam logic [4:0] MODE_ABT = 5'h17;
  localparam logic [4:0] MODE_UND = 5'h1B;
  localparam logic [4:0] MODE_SYS = 5'h1F;

  // Storage layout.
  localparam int STORE_ENTRIES = 37;
  localparam int SLOT_W        = $clog2(STORE_ENTRIES);

  typedef logic [SLOT_W-1:0] slot_t;

  localparam slot_t SLOT_CPSR     = slot_t'(16);
  localparam slot_t SLOT_FIQ_R8   = slot_t'(17);
  localparam slot_t SLOT_SVC_R13  = slot_t'(24);
  localparam slot_t SLOT_ABT_R13  = slot_t'(26);
  localparam slot_t SLOT_UND_R13  = slot_t'(28);
  localparam slot_t SLOT_IRQ_R13  = slot_t'(30);
  localparam slot_t SLOT_SPSR_FIQ = slot_t'(32);
  localparam slot_t SLOT_SPSR_SVC = slot_t'(33);
  localparam slot_t SLOT_SPSR_ABT = slot_t'(34);
  localparam slot_t SLOT_SPSR_UND = slot_t'(35);
  localparam slot_t SLOT_SPSR_IRQ = slot_t'(36);

  localparam logic [31:0] CPSR_RESET = 32'h0000_0010;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic access;
    logic load;
  } brf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } brf_stat_t;

  // Result of mapping an access onto the store.
  typedef struct packed {
    logic  hit;
    slot_t slot;
  } slot_map_t;

  // True for the five exception modes that own an SPSR.
  function automatic logic owns_spsr(input logic [4:0] mode);
    return (mode == MODE_FIQ) || (mode == MODE_IRQ) || (mode == MODE_SVC) ||
           (mode == MODE_ABT) || (mode == MODE_UND);
  endfunction

  // True for every valid mode except user.
  function automatic logic is_priv(input logic [4:0] mode);
    return owns_spsr(mode) || (mode == MODE_SYS);
  endfunction

  // Maps an operation onto a store slot; hit is low when no slot is touched.
  function automatic slot_map_t map_slot(input logic [2:0] op, input logic [3:0] reg_idx,
                                         input logic [4:0] mode);
    slot_map_t r;
    slot_t     plain;
    plain  = slot_t'(reg_idx);
    r.hit  = 1'b1;
    r.slot = plain;
    case (op)
      OP_RD_BANKED, OP_WR_BANKED: begin
        if (mode == MODE_FIQ && reg_idx >= 4'd8 && reg_idx <= 4'd14) begin
          r.slot = SLOT_FIQ_R8 + plain - slot_t'(8);
        end else if (reg_idx == 4'd13 || reg_idx == 4'd14) begin
          case (mode)
            MODE_SVC: r.slot = SLOT_SVC_R13 + plain - slot_t'(13);
            MODE_ABT: r.slot = SLOT_ABT_R13 + plain - slot_t'(13);
            MODE_UND: r.slot = SLOT_UND_R13 + plain - slot_t'(13);
            MODE_IRQ: r.slot = SLOT_IRQ_R13 + plain - slot_t'(13);
            default:  r.slot = plain;
          endcase
        end
      end
      OP_RD_USER, OP_WR_USER: begin
        r.slot = plain;
      end
      OP_RD_SPSR, OP_WR_SPSR: begin
        case (mode)
          MODE_FIQ: r.slot = SLOT_SPSR_FIQ;
          MODE_SVC: r.slot = SLOT_SPSR_SVC;
          MODE_ABT: r.slot = SLOT_SPSR_ABT;
          MODE_UND: r.slot = SLOT_SPSR_UND;
          MODE_IRQ: r.slot = SLOT_SPSR_IRQ;
          default:  r.hit  = 1'b0;
        endcase
      end
      default: begin
        // CPSR accesses use the dedicated status register.
        r.hit = 1'b0;
      end
    endcase
    return r;
  endfunction

endpackage

### sv/brf_ctrl.sv
// Sequencing controller for the banked register file.
module brf_ctrl import brf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  brf_stat_t stat,
  output brf_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ACCESS = 2'd1;
  localparam logic [1:0] ST_LOAD   = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Command decode from the current state; no transfer is taken during reset.
  always_comb begin
    s_tready    = (state == ST_IDLE) && !rst;
    cmd.capture = s_tvalid && s_tready;
    cmd.access  = (state == ST_ACCESS);
    cmd.load    = (state == ST_LOAD) && !stat.out_busy;
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_ACCESS;
      ST_ACCESS: state_next = ST_LOAD;
      ST_LOAD:   if (!stat.out_busy) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A result is never loaded over one that is still waiting.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !stat.out_busy)
    else $error("result loaded while output register busy");

  // Every captured transfer goes straight to the store access.
  a_capture_access: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.access)
    else $error("capture not followed by access");

endmodule

### sv/brf_datapath.sv
// Register store, CPSR, slot mapping and result register.
module brf_datapath import brf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  brf_cmd_t    cmd,
  output brf_stat_t   stat,
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata
);

  // Captured request.
  logic [2:0]  op_q;
  logic [3:0]  reg_q;
  logic [31:0] val_q;

  // Status register and the banked store with per-entry valid bits.
  logic [31:0]              cpsr;
  logic [31:0]              mem [0:STORE_ENTRIES-1];
  logic [STORE_ENTRIES-1:0] valid;
  logic [31:0]              mem_rdata;
  logic                     rd_hit;

  // Result register.
  logic        out_valid;
  logic [31:0] out_data;
  logic [4:0]  out_mode;
  logic        out_spsr;
  logic        out_priv;

  slot_map_t map;
  logic      mem_we;
  logic      is_read;
  logic [4:0] mode;

  assign mode    = cpsr[4:0];
  assign map     = map_slot(op_q, reg_q, mode);
  assign is_read = !op_q[0];
  assign mem_we  = cmd.access && !is_read && map.hit;

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= s_tdata[2:0];
      reg_q <= s_tdata[6:3];
      val_q <= s_tdata[38:7];
    end
  end

  // CPSR update.
  always_ff @(posedge clk) begin
    if (rst) begin
      cpsr <= CPSR_RESET;
    end else if (cmd.access && op_q == OP_WR_CPSR) begin
      cpsr <= val_q;
    end
  end

  // Store write and registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[map.slot] <= val_q;
    end
    if (cmd.access) begin
      mem_rdata <= mem[map.slot];
    end
  end

  // Valid bits stand in for clearing the store at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (mem_we) begin
        valid[map.slot] <= 1'b1;
      end
      if (cmd.access) begin
        rd_hit <= map.hit && valid[map.slot];
      end
    end
  end

  // Result payload, built from the state after the operation.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (!is_read) begin
        out_data <= '0;
      end else if (op_q == OP_RD_CPSR) begin
        out_data <= cpsr;
      end else begin
        out_data <= rd_hit ? mem_rdata : 32'd0;
      end
      out_mode <= mode;
      out_spsr <= owns_spsr(mode);
      out_priv <= is_priv(mode);
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.out_busy = out_valid && !m_tready;
  assign m_tvalid      = out_valid;
  assign m_tdata       = {1'b0, out_priv, out_spsr, out_mode, out_data};

  // The CPSR slot of the store is never written; the CPSR has its own register.
  a_no_cpsr_slot: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> map.slot != SLOT_CPSR)
    else $error("store write to CPSR slot");

  // SPSR writes only land when the mode owns an SPSR.
  a_spsr_owner: assert property (@(posedge clk) disable iff (rst)
    (mem_we && op_q == OP_WR_SPSR) |-> owns_spsr(mode))
    else $error("SPSR write in a mode without SPSR");

  // A loaded result is offered on the next cycle.
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> m_tvalid)
    else $error("loaded result not offered");

endmodule

### sv/banked_register_file.sv
// Top level of the banked register file: controller plus datapath.
//
// Banked processor register file with 37 words: r0..r15, the CPSR, the FIQ
// copies of r8..r14, r13/r14 copies for SVC, ABT, UND and IRQ, and one SPSR
// per exception mode. Each input transfer carries one operation and yields
// exactly one result transfer. The controller takes each operation through
// three steps (capture, store access, result load); the result is registered
// at the load and offered from the output register, and the next input
// transfer is accepted only after the result load, so a new operation is not
// taken before the previous one has been loaded. The result load waits for as
// long as an earlier result is still held on the output, which stalls the
// input as well. A new operation is accepted while a finished result still
// waits on the output. No transfer is taken while reset is high. After reset
// the store reads as zero and the CPSR as user mode at once: per-entry valid
// bits replace a clearing pass.
module banked_register_file import brf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // opcode[2:0], reg_index[6:3], write_value[38:7], pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata   // read_data[31:0], current_mode[36:32],
                                // spsr_present[37], privileged[38], pad
);

  brf_cmd_t  cmd;
  brf_stat_t stat;

  // Sequencing.
  brf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage and result path.
  brf_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
